// ----- hdl/bfs_pkg.sv -----
// Package for the BMP fit scaler: constants, command and status codes,
// FSM state type and the header byte address table. No dependencies.
`timescale 1ns / 1ps
package bfs_pkg;

    localparam int BUFFER_BYTES = 262144;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = ADDR_W + 1;
    localparam int HDR_BYTES    = 54;
    localparam int HDR_N        = 20;
    localparam int HDR_IDX_W    = 5;
    localparam logic [7:0] SIG_B = 8'h42;
    localparam logic [7:0] SIG_M = 8'h4D;
    localparam logic [15:0] BPP_24 = 16'd24;
    localparam logic [15:0] BPP_32 = 16'd32;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_START = 2'd2,
        CMD_NEXT  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_SIG   = 3'd1,
        STAT_BAD_FMT   = 3'd2,
        STAT_TRUNC     = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_NO_IMAGE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_BOX_LEFT   = 2'd0,
        REG_BOX_TOP    = 2'd1,
        REG_BOX_WIDTH  = 2'd2,
        REG_BOX_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        DIV_SRC_W = 2'd0,
        DIV_SRC_H = 2'd1,
        DIV_OUT_W = 2'd2,
        DIV_OUT_H = 2'd3
    } div_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_HDR_RD, ST_HDR_END, ST_HDR_CHK, ST_BND_MUL, ST_BND_CHK,
        ST_DIV_GO, ST_DIV_WAIT, ST_ORIGIN, ST_PX_MUL, ST_PX_ROW, ST_PX_SCALE,
        ST_PX_ADDR, ST_PX_RB, ST_PX_RG, ST_PX_RR, ST_PX_FIN, ST_RESP
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic [15:0] pixel_color;
        logic [15:0] scaled_width;
        logic [15:0] scaled_height;
        logic        last_pixel;
    } result_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

    // Header bytes fetched in order: signature, pixel offset, width,
    // height, bit count, compression.
    function automatic logic [ADDR_W-1:0] hdr_addr(input logic [HDR_IDX_W-1:0] idx);
        logic [5:0] a;
        case (idx) inside
            [5'd0:5'd1]:   a = 6'(idx);
            [5'd2:5'd5]:   a = 6'(idx) + 6'd8;
            [5'd6:5'd13]:  a = 6'(idx) + 6'd12;
            [5'd14:5'd19]: a = 6'(idx) + 6'd14;
            default:       a = 6'd0;
        endcase
        return ADDR_W'(a);
    endfunction

endpackage

// ----- hdl/bfs_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- hdl/bfs_div.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on bfs_pkg for the request and response structs.
`timescale 1ns / 1ps
module bfs_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  bfs_pkg::div_req_t req,
    output bfs_pkg::div_rsp_t rsp
);
    import bfs_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic        done_reg;
    logic [32:0] shifted;
    logic        fits;

    assign shifted = {rem_reg, quo_reg[31]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= 32'd0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? 32'(shifted - {1'b0, dvs_reg}) : shifted[31:0];
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ----- hdl/bmp_fit_scaler_rgb565.sv -----
// BMP fit scaler: loads a 24/32-bit BMP into a byte buffer and emits a
// nearest-neighbour downscaled image as RGB565 pixels.
// Steps per item: clear and load are answered straight from idle; next pixel
// runs address setup, then three buffer reads on the single port; start runs
// 20 header reads, then four divides on the shared divider. One item at a
// time; a stalled result holds off the next item.
// Reset (aresetn, synchronous, active low) clears control state and the box
// registers; the buffer contents are left undefined.
`timescale 1ns / 1ps
module bmp_fit_scaler_rgb565 (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [7:0]  s_data_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic signed [15:0] m_pixel_x,
    output logic signed [15:0] m_pixel_y,
    output logic [15:0] m_pixel_color,
    output logic [15:0] m_scaled_width,
    output logic [15:0] m_scaled_height,
    output logic        m_last_pixel,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bfs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [15:0] box_left_reg, box_top_reg, box_width_reg, box_height_reg;
    reg_idx_t    cfg_idx;

    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_left_reg   <= 16'd0;
            box_top_reg    <= 16'd0;
            box_width_reg  <= 16'd240;
            box_height_reg <= 16'd320;
        end else if (psel && penable && pwrite) begin
            case (cfg_idx)
                REG_BOX_LEFT:   box_left_reg   <= pwdata[15:0];
                REG_BOX_TOP:    box_top_reg    <= pwdata[15:0];
                REG_BOX_WIDTH:  box_width_reg  <= pwdata[15:0];
                REG_BOX_HEIGHT: box_height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_BOX_LEFT:   prdata = {16'd0, box_left_reg};
            REG_BOX_TOP:    prdata = {16'd0, box_top_reg};
            REG_BOX_WIDTH:  prdata = {16'd0, box_width_reg};
            REG_BOX_HEIGHT: prdata = {16'd0, box_height_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- state ----------------
    state_t state_reg, state_next;
    cmd_t   cmd;
    logic   s_xfer;

    logic [CNT_W-1:0]     byte_count_reg;
    logic                 active_reg;
    logic [31:0]          offset_reg, src_w_reg, src_h_reg, stride_reg, div_reg;
    logic [2:0]           bpp_reg;
    logic                 top_down_reg;
    logic [15:0]          origin_x_reg, origin_y_reg, cur_x_reg, cur_y_reg;
    logic [31:0]          out_w_reg, out_h_reg, q0_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic                 rd_pend_reg;
    logic [8*HDR_N-1:0]   hdr_reg;
    logic [63:0]          prod_reg;
    logic                 off_big_reg;
    div_sel_t             div_sel_reg;
    logic [31:0]          sy_reg, xo_reg, srow_reg, rowoff_reg, xb_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [7:0]           blue_reg, green_reg;
    result_t              res_reg, out_reg;
    result_t              idle_res;
    logic                 m_valid_reg;

    assign cmd    = cmd_t'(s_command);
    assign s_ready = (state_reg == ST_IDLE);
    assign s_xfer  = s_valid && s_ready;

    // header fields, bytes in little-endian order
    logic [7:0]  h_sig0, h_sig1;
    logic [31:0] h_off, h_w, h_hraw, h_comp;
    logic [15:0] h_bpp;
    assign h_sig0 = hdr_reg[7:0];
    assign h_sig1 = hdr_reg[15:8];
    assign h_off  = hdr_reg[47:16];
    assign h_w    = hdr_reg[79:48];
    assign h_hraw = hdr_reg[111:80];
    assign h_bpp  = hdr_reg[127:112];
    assign h_comp = hdr_reg[159:128];

    logic sig_bad, fmt_bad;
    assign sig_bad = (h_sig0 != SIG_B) || (h_sig1 != SIG_M);
    assign fmt_bad = (h_w == 32'd0) || h_w[31] || (h_hraw == 32'd0) ||
                     (h_comp != 32'd0) || ((h_bpp != BPP_24) && (h_bpp != BPP_32));

    // ---------------- buffer ----------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    logic              buf_full;

    assign buf_full = byte_count_reg >= CNT_W'(BUFFER_BYTES);

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = byte_count_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:   ram_we   = s_xfer && (cmd == CMD_LOAD) && !buf_full;
            ST_HDR_RD: ram_addr = hdr_addr(hdr_idx_reg);
            ST_PX_RB:  ram_addr = addr_reg;
            ST_PX_RG:  ram_addr = addr_reg + ADDR_W'(1);
            ST_PX_RR:  ram_addr = addr_reg + ADDR_W'(2);
            default: ;
        endcase
    end

    bfs_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data_byte),
        .rdata (ram_rdata)
    );

    // ---------------- shared divider ----------------
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        case (div_sel_reg)
            DIV_SRC_W: begin
                div_req.dividend = src_w_reg;
                div_req.divisor  = 32'(box_width_reg) + 32'd1;
            end
            DIV_SRC_H: begin
                div_req.dividend = src_h_reg;
                div_req.divisor  = 32'(box_height_reg) + 32'd1;
            end
            DIV_OUT_W: begin
                div_req.dividend = src_w_reg;
                div_req.divisor  = div_reg;
            end
            default: begin
                div_req.dividend = src_h_reg;
                div_req.divisor  = div_reg;
            end
        endcase
    end

    bfs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // ---------------- next state ----------------
    logic out_free;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    case (cmd)
                        CMD_START: state_next = (byte_count_reg < CNT_W'(HDR_BYTES)) ?
                                                ST_RESP : ST_HDR_RD;
                        CMD_NEXT:  state_next = active_reg ? ST_PX_MUL : ST_RESP;
                        default:   state_next = ST_RESP;
                    endcase
                end
            end
            ST_HDR_RD:
                if (hdr_idx_reg == HDR_IDX_W'(HDR_N - 1)) state_next = ST_HDR_END;
            ST_HDR_END:  state_next = ST_HDR_CHK;
            ST_HDR_CHK:  state_next = (sig_bad || fmt_bad) ? ST_RESP : ST_BND_MUL;
            ST_BND_MUL:  state_next = ST_BND_CHK;
            ST_BND_CHK:
                state_next = (off_big_reg ||
                              prod_reg > 64'(32'(byte_count_reg) - offset_reg)) ?
                             ST_RESP : ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
                if (div_rsp.done)
                    state_next = (div_sel_reg == DIV_OUT_H) ? ST_ORIGIN : ST_DIV_GO;
            ST_ORIGIN:   state_next = ST_RESP;
            ST_PX_MUL:   state_next = ST_PX_ROW;
            ST_PX_ROW:   state_next = ST_PX_SCALE;
            ST_PX_SCALE: state_next = ST_PX_ADDR;
            ST_PX_ADDR:  state_next = ST_PX_RB;
            ST_PX_RB:    state_next = ST_PX_RG;
            ST_PX_RG:    state_next = ST_PX_RR;
            ST_PX_RR:    state_next = ST_PX_FIN;
            ST_PX_FIN:   state_next = ST_RESP;
            ST_RESP:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else          state_reg <= state_next;
    end

    // result of a command that is answered straight from idle
    always_comb begin
        idle_res = '0;
        if (s_xfer) begin
            case (cmd)
                CMD_LOAD:  if (buf_full) idle_res.status = STAT_FULL;
                CMD_START: idle_res.status = STAT_BAD_SIG;
                CMD_NEXT:  if (!active_reg) idle_res.status = STAT_NO_IMAGE;
                default: ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    logic [31:0] h_abs;
    logic [2:0]  bpp_bytes;
    logic [33:0] stride_raw;
    logic [31:0] diff_w, diff_h;
    logic        last_x, last_y;

    assign h_abs      = h_hraw[31] ? (32'd0 - h_hraw) : h_hraw;
    assign bpp_bytes  = (h_bpp == BPP_32) ? 3'd4 : 3'd3;
    assign stride_raw = 34'(h_w) * 34'(bpp_bytes) + 34'd3;
    assign diff_w     = 32'(box_width_reg) - out_w_reg;
    assign diff_h     = 32'(box_height_reg) - out_h_reg;
    assign last_x     = (32'(17'(cur_x_reg) + 17'd1) == out_w_reg);
    assign last_y     = (32'(17'(cur_y_reg) + 17'd1) == out_h_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            active_reg     <= 1'b0;
            offset_reg     <= 32'd0;
            src_w_reg      <= 32'd0;
            src_h_reg      <= 32'd0;
            bpp_reg        <= 3'd0;
            top_down_reg   <= 1'b0;
            stride_reg     <= 32'd0;
            div_reg        <= 32'd1;
            origin_x_reg   <= 16'd0;
            origin_y_reg   <= 16'd0;
            cur_x_reg      <= 16'd0;
            cur_y_reg      <= 16'd0;
            hdr_idx_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            div_sel_reg    <= DIV_SRC_W;
            m_valid_reg    <= 1'b0;
        end else begin
            rd_pend_reg <= (state_reg == ST_HDR_RD);
            // raise valid with a new result, drop it once the transfer completes
            if (state_reg == ST_RESP && out_free) m_valid_reg <= 1'b1;
            else if (m_ready)                     m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    hdr_idx_reg <= '0;
                    div_sel_reg <= DIV_SRC_W;
                    if (s_xfer) begin
                        case (cmd)
                            CMD_CLEAR: begin
                                byte_count_reg <= '0;
                                active_reg     <= 1'b0;
                            end
                            CMD_LOAD:
                                if (!buf_full) byte_count_reg <= byte_count_reg + CNT_W'(1);
                            CMD_START: active_reg <= 1'b0;
                            default: ;
                        endcase
                    end
                end
                ST_HDR_RD: hdr_idx_reg <= hdr_idx_reg + HDR_IDX_W'(1);
                ST_HDR_CHK:
                    if (!sig_bad && !fmt_bad) begin
                        top_down_reg <= h_hraw[31];
                        bpp_reg      <= bpp_bytes;
                        stride_reg   <= {stride_raw[31:2], 2'b00};
                        offset_reg   <= h_off;
                        src_w_reg    <= h_w;
                        src_h_reg    <= h_abs;
                    end
                ST_DIV_WAIT:
                    if (div_rsp.done) begin
                        div_sel_reg <= div_sel_t'(div_sel_reg + 2'd1);
                        if (div_sel_reg == DIV_SRC_H)
                            div_reg <= ((div_rsp.quotient > q0_reg) ?
                                        div_rsp.quotient : q0_reg) + 32'd1;
                    end
                ST_ORIGIN: begin
                    origin_x_reg <= box_left_reg + diff_w[16:1];
                    origin_y_reg <= box_top_reg + diff_h[16:1];
                    cur_x_reg    <= 16'd0;
                    cur_y_reg    <= 16'd0;
                    active_reg   <= (out_w_reg != 32'd0) && (out_h_reg != 32'd0);
                end
                ST_PX_FIN: begin
                    // advance raster cursor; drop the image after its last pixel
                    if (last_x && last_y) begin
                        active_reg <= 1'b0;
                    end else if (last_x) begin
                        cur_x_reg <= 16'd0;
                        cur_y_reg <= cur_y_reg + 16'd1;
                    end else begin
                        cur_x_reg <= cur_x_reg + 16'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (rd_pend_reg) hdr_reg <= {ram_rdata, hdr_reg[8*HDR_N-1:8]};
        if (state_reg == ST_RESP && out_free) out_reg <= res_reg;
        case (state_reg)
            ST_IDLE: res_reg <= idle_res;
            ST_HDR_CHK:
                res_reg.status <= sig_bad ? STAT_BAD_SIG :
                                  (fmt_bad ? STAT_BAD_FMT : STAT_TRUNC);
            ST_BND_MUL: begin
                prod_reg    <= 64'(stride_reg) * 64'(src_h_reg);
                off_big_reg <= offset_reg > 32'(byte_count_reg);
            end
            ST_DIV_WAIT:
                if (div_rsp.done) begin
                    case (div_sel_reg)
                        DIV_SRC_W: q0_reg    <= div_rsp.quotient;
                        DIV_OUT_W: out_w_reg <= div_rsp.quotient;
                        DIV_OUT_H: out_h_reg <= div_rsp.quotient;
                        default: ;
                    endcase
                end
            ST_ORIGIN: begin
                res_reg.status        <= STAT_OK;
                res_reg.scaled_width  <= out_w_reg[15:0];
                res_reg.scaled_height <= out_h_reg[15:0];
            end
            ST_PX_MUL: begin
                sy_reg <= 32'(48'(cur_y_reg) * 48'(div_reg));
                xo_reg <= 32'(48'(cur_x_reg) * 48'(div_reg));
            end
            ST_PX_ROW:
                srow_reg <= top_down_reg ? sy_reg : (src_h_reg - 32'd1 - sy_reg);
            ST_PX_SCALE: begin
                rowoff_reg <= 32'(64'(srow_reg) * 64'(stride_reg));
                xb_reg     <= (bpp_reg == 3'd4) ? {xo_reg[29:0], 2'b00}
                                                : xo_reg + {xo_reg[30:0], 1'b0};
            end
            ST_PX_ADDR: addr_reg <= ADDR_W'(offset_reg + rowoff_reg + xb_reg);
            ST_PX_RG:   blue_reg  <= ram_rdata;
            ST_PX_RR:   green_reg <= ram_rdata;
            ST_PX_FIN: begin
                res_reg.status        <= STAT_OK;
                res_reg.pixel_x       <= origin_x_reg + cur_x_reg;
                res_reg.pixel_y       <= origin_y_reg + cur_y_reg;
                res_reg.pixel_color   <= {ram_rdata[7:3], green_reg[7:2], blue_reg[7:3]};
                res_reg.scaled_width  <= out_w_reg[15:0];
                res_reg.scaled_height <= out_h_reg[15:0];
                res_reg.last_pixel    <= last_x && last_y;
            end
            default: ;
        endcase
    end

    // ---------------- outputs ----------------
    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_pixel_x       = out_reg.pixel_x;
    assign m_pixel_y       = out_reg.pixel_y;
    assign m_pixel_color   = out_reg.pixel_color;
    assign m_scaled_width  = out_reg.scaled_width;
    assign m_scaled_height = out_reg.scaled_height;
    assign m_last_pixel    = out_reg.last_pixel;
endmodule
